>>> design/bfr_pkg.sv
package bfr_pkg;

    localparam int PROD_W = 32;
    localparam int PART_W = 35;
    localparam int SUM_W  = 40;
    localparam int FRAC_W = 13;

    typedef logic [15:0] t_sample;
    // channels: a_red, a_green, a_blue, b_red, b_green, b_blue
    typedef logic [5:0][15:0] t_pix;
    // two stored lines of one column, [0] is the older
    typedef logic [1:0][5:0][15:0] t_line;
    // one window column, [0] is the oldest row
    typedef logic [2:0][5:0][15:0] t_col;
    typedef logic signed [PART_W-1:0] t_part;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              v;
        logic              int_v;
        logic              bord_v;
        logic              par;
        logic [10:0]       int_col;
        logic [10:0]       int_row;
        logic [10:0]       bord_col;
        logic [10:0]       bord_row;
        logic [3:0][15:0]  bord_q;   // top_left, top_right, bottom_left, bottom_right
    } t_meta;

    // [site][parity][channel][row*3+col]
    localparam logic signed [15:0] COEF [4][2][6][9] = '{
        '{
            '{ '{17,-87,-27,-463,497,-26,189,-221,-3},
               '{-2549,2702,-73,-277,537,40,3950,-3976,47},
               '{2540,-2501,-130,881,-987,-292,-4222,4176,-153},
               '{532,-295,-48,3374,-2774,35,-10387,10458,16},
               '{-515,645,-56,-4905,11107,190,10386,-10213,-100},
               '{-178,95,-34,2130,-686,-29,-161,121,-88} },
            '{ '{-8,-360,355,-113,361,-1594,138,51,-302},
               '{85,8568,-8264,128,-9194,9167,49,-1701,1878},
               '{32,-7766,7688,79,9079,-8702,-74,1793,-1796},
               '{-243,14363,-14345,-68,685,2031,-133,-2819,2781},
               '{-80,-14095,14148,375,8186,-2135,-163,3080,-3086},
               '{-33,157,-43,9,-589,554,-19,66,52} } },
        '{
            '{ '{567,-577,174,114,-44,-384,-72,260,-16},
               '{617,-393,-14,8087,-7671,-710,741,-868,-47},
               '{-1344,1352,647,-7923,8321,4918,-735,608,793},
               '{-3509,3389,-38,-2787,2812,167,14593,-14702,-61},
               '{3399,-3717,-259,2445,-2093,651,-14566,14225,-60},
               '{174,-115,85,566,104,707,-48,133,312} },
            '{ '{-51,-155,410,-8,-281,496,91,223,-236},
               '{-29,-688,1069,-60,1345,-1225,18,-1678,1589},
               '{-63,1469,-1389,197,-240,956,-116,1615,-1395},
               '{-183,6555,-6596,-85,-4934,4731,20,-5176,5053},
               '{-11,-6824,6288,24,3998,-3497,-126,5238,-5642},
               '{-113,850,-39,211,6028,-225,-107,710,194} } },
        '{
            '{ '{464,-524,-122,-326,951,387,-104,21,-83},
               '{-8348,8083,-79,4527,-3959,230,-3018,2623,-30},
               '{7664,-7586,-30,-3884,3730,18,2734,-2820,-44},
               '{9398,-8421,-99,1177,5070,266,-3032,3936,-42},
               '{-9194,8993,-11,-1766,1417,-21,2541,-2394,-190},
               '{-347,259,90,802,-711,-37,498,-359,-93} },
            '{ '{-165,-194,866,192,263,5460,-149,-32,654},
               '{-221,5416,-5716,263,13406,-13528,-175,-3649,3261},
               '{44,-5604,5608,43,-13116,12935,-85,3325,-3198},
               '{215,-2989,2957,526,8633,-7560,144,1149,-1040},
               '{29,2515,-2704,-353,-7354,8103,-62,-601,763},
               '{-1,256,-216,-76,-43,-64,21,-276,332} } },
        '{
            '{ '{65,4,-66,590,-145,169,-257,335,-110},
               '{5358,-5380,-148,-3296,9438,248,-291,344,-118},
               '{-5643,5667,-59,3132,-2045,105,366,-371,101},
               '{-359,326,-96,-6351,6546,148,3276,-3338,58},
               '{524,-416,40,6370,-6356,287,-3268,3512,85},
               '{-236,128,31,-493,3,-92,-128,82,-73} },
            '{ '{3,-212,158,-100,-1503,4434,63,-172,35},
               '{-16,5670,-5584,217,20874,-15239,-30,-3319,3400},
               '{22,-4978,5059,140,-11578,11114,-23,3964,-3788},
               '{-316,7759,-7823,-1557,4812,-4535,-340,197,-104},
               '{38,-7236,7264,107,-4937,5463,-133,-218,607},
               '{-4,-473,467,98,673,-390,-25,603,-404} } }
    };

endpackage

>>> design/bfr_line.sv
module bfr_line
    import bfr_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line         i_wr_data,
    output t_line         o_rd_data
);

    t_line r_mem [DEPTH];
    t_line r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            // forward a write to the same column in this cycle
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

>>> design/bfr_cell.sv
module bfr_cell
    import bfr_pkg::*;
#(
    parameter int COL = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  logic  i_shift,
    input  t_col  i_col,
    input  logic  i_par,
    output t_col  o_col,
    output t_part o_part [4][3]
);

    t_col                     r_pix;
    logic signed [PROD_W-1:0] r_prod [4][3][6];
    t_part                    r_part [4][3];
    t_part                    n_part [4][3];

    function automatic logic signed [PROD_W-1:0] mul(logic signed [15:0] c, t_sample x);
        logic signed [PROD_W-1:0] ce;
        logic signed [PROD_W-1:0] xe;
        ce = PROD_W'(c);
        xe = $signed(PROD_W'(x));
        return ce * xe;
    endfunction

    always_comb begin
        for (int s = 0; s < 4; s++) begin
            for (int r = 0; r < 3; r++) begin
                n_part[s][r] = '0;
                for (int c = 0; c < 6; c++) begin
                    n_part[s][r] = n_part[s][r] + PART_W'(r_prod[s][r][c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pix <= i_col;
        end
        if (i_en) begin
            for (int s = 0; s < 4; s++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 6; c++) begin
                        r_prod[s][r][c] <= mul(COEF[s][i_par][c][r*3+COL], r_pix[r][c]);
                    end
                    r_part[s][r] <= n_part[s][r];
                end
            end
        end
    end

    assign o_col  = r_pix;
    assign o_part = r_part;

endmodule

>>> design/bfr_outq.sv
module bfr_outq
    import bfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_meta       i_meta,
    input  t_sample     i_site [4],
    input  logic        i_out_stall,
    output logic        o_en,
    output logic        o_out_valid,
    output logic [10:0] o_out_col,
    output logic [10:0] o_out_row,
    output logic [15:0] o_top_left,
    output logic [15:0] o_top_right,
    output logic [15:0] o_bottom_left,
    output logic [15:0] o_bottom_right,
    output logic        o_is_border,
    output logic        o_last
);

    logic             r_pend_i;
    logic             r_pend_b;
    logic [10:0]      r_int_col;
    logic [10:0]      r_int_row;
    logic [10:0]      r_bord_col;
    logic [10:0]      r_bord_row;
    logic [3:0][15:0] r_int_q;
    logic [3:0][15:0] r_bord_q;
    logic             w_acc;

    assign o_out_valid = r_pend_i | r_pend_b;
    assign w_acc       = o_out_valid & ~i_out_stall;
    // take a new item once the held one is gone after this cycle
    assign o_en        = ~o_out_valid | (w_acc & ~(r_pend_i & r_pend_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_i <= 1'b0;
            r_pend_b <= 1'b0;
        end else if (o_en) begin
            r_pend_i <= i_meta.v & i_meta.int_v;
            r_pend_b <= i_meta.v & i_meta.bord_v;
        end else if (w_acc) begin
            if (r_pend_i) begin
                r_pend_i <= 1'b0;
            end else begin
                r_pend_b <= 1'b0;
            end
        end
        if (o_en) begin
            r_int_col  <= i_meta.int_col;
            r_int_row  <= i_meta.int_row;
            r_bord_col <= i_meta.bord_col;
            r_bord_row <= i_meta.bord_row;
            r_bord_q   <= i_meta.bord_q;
            for (int s = 0; s < 4; s++) begin
                r_int_q[s] <= i_site[s];
            end
        end
    end

    // interior quad goes first, border quad second
    assign o_out_col      = r_pend_i ? r_int_col : r_bord_col;
    assign o_out_row      = r_pend_i ? r_int_row : r_bord_row;
    assign o_top_left     = r_pend_i ? r_int_q[0] : r_bord_q[0];
    assign o_top_right    = r_pend_i ? r_int_q[1] : r_bord_q[1];
    assign o_bottom_left  = r_pend_i ? r_int_q[2] : r_bord_q[2];
    assign o_bottom_right = r_pend_i ? r_int_q[3] : r_bord_q[3];
    assign o_is_border    = ~r_pend_i;
    assign o_last         = ~(r_pend_i & r_pend_b);

endmodule

>>> design/dual_frame_bayer_recovery_filter_top.sv
// Dual-frame Bayer recovery filter.
// Input channel: one pixel position per item, the six co-located samples of
// frames A and B in raster order; start_of_frame puts the item at (0,0).
// Output channel: 2x2 Bayer quads. An item gives up to two quads: the
// filtered quad of the position up and left of it, once its 3x3 window is
// complete, then a copied quad when the item lies on the frame border.
// o_last marks the final quad of an item; items in column 1 or row 1 that
// are not on the border give nothing.
// Throughput: one item per cycle; an item that gives two quads holds
// the input while its interior quad is sent, since the output moves one
// quad per cycle. The first quad of an item passes through these steps
// in order: line memory read at acceptance, window column shift,
// products, row sums, site sums, output register.
// A stall on the output freezes the whole pipeline and stalls the input.
// Reset clears position and valid state and sets frame_width 1920 and
// frame_height 1080; line memory and window contents stay undefined.
// Write frame_width/frame_height only while the block is idle.
module dual_frame_bayer_recovery_filter_top
    import bfr_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_of_frame,
    input  logic [15:0] i_a_red,
    input  logic [15:0] i_a_green,
    input  logic [15:0] i_a_blue,
    input  logic [15:0] i_b_red,
    input  logic [15:0] i_b_green,
    input  logic [15:0] i_b_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_out_col,
    output logic [10:0] o_out_row,
    output logic [15:0] o_top_left,
    output logic [15:0] o_top_right,
    output logic [15:0] o_bottom_left,
    output logic [15:0] o_bottom_right,
    output logic        o_is_border,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = 14;
    localparam logic [DW-1:0] WMAX    = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] HMAX    = DW'(MAX_HEIGHT);
    localparam logic [DW-1:0] DIM_MIN = DW'(3);

    logic [11:0]   r_fw;
    logic [11:0]   r_fh;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [DW-1:0] w_w;
    logic [DW-1:0] w_h;
    logic [DW-1:0] w_cx;
    logic [DW-1:0] w_cy;
    logic [DW-1:0] n_col;
    logic [DW-1:0] n_row;
    logic          w_en;
    logic          w_acc;
    t_pix          w_cur;
    t_meta         n_meta;

    logic          r_s1_v;
    logic [CW-1:0] r_s1_addr;
    t_pix          r_s1_cur;
    t_meta         r_s1_meta;
    t_meta         n_s2_meta;
    t_meta         r_s2_meta;
    t_meta         r_s3_meta;
    t_meta         r_s4_meta;
    t_meta         r_s5_meta;
    t_line         w_rd;
    t_line         w_wr;
    t_col          w_new_col;
    t_col          w_cell_col [3];
    t_part         w_part [3][4][3];
    logic signed [SUM_W-1:0] n_sum [4];
    logic signed [SUM_W-1:0] r_sum [4];
    t_sample       w_site [4];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 12'd1920;
            r_fh <= 12'd1080;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        w_w = DW'(r_fw);
        if (w_w < DIM_MIN) begin
            w_w = DIM_MIN;
        end else if (w_w > WMAX) begin
            w_w = WMAX;
        end
        w_h = DW'(r_fh);
        if (w_h < DIM_MIN) begin
            w_h = DIM_MIN;
        end else if (w_h > HMAX) begin
            w_h = HMAX;
        end
    end

    // position of this item, wrapped against the current frame size
    always_comb begin
        w_cx = DW'(r_col);
        w_cy = DW'(r_row);
        if (i_start_of_frame) begin
            w_cx = '0;
            w_cy = '0;
        end
        if (w_cx >= w_w) begin
            w_cx = '0;
            w_cy = w_cy + DW'(1);
        end
        if (w_cy >= w_h) begin
            w_cy = '0;
        end
        n_col = w_cx + DW'(1);
        n_row = w_cy;
        if (n_col >= w_w) begin
            n_col = '0;
            n_row = w_cy + DW'(1);
            if (n_row >= w_h) begin
                n_row = '0;
            end
        end
    end

    assign w_cur = {i_b_blue, i_b_green, i_b_red, i_a_blue, i_a_green, i_a_red};

    always_comb begin
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        x = w_cx - DW'(1);
        y = w_cy - DW'(1);
        n_meta          = '0;
        n_meta.v        = 1'b1;
        n_meta.int_v    = (w_cx >= DW'(2)) && (w_cy >= DW'(2));
        n_meta.bord_v   = (w_cx == '0) || (w_cy == '0) ||
                          (w_cx == w_w - DW'(1)) || (w_cy == w_h - DW'(1));
        n_meta.par      = w_cx[0];
        n_meta.int_col  = x[10:0];
        n_meta.int_row  = y[10:0];
        n_meta.bord_col = w_cx[10:0];
        n_meta.bord_row = w_cy[10:0];
        n_meta.bord_q   = {i_a_green, i_b_red, i_b_blue, i_b_green};
    end

    assign w_acc      = i_in_valid & w_en;
    assign o_in_stall = ~w_en;

    always_comb begin
        n_s2_meta   = r_s1_meta;
        n_s2_meta.v = r_s1_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_v    <= 1'b0;
            r_s2_meta <= '0;
            r_s3_meta <= '0;
            r_s4_meta <= '0;
            r_s5_meta <= '0;
        end else if (w_en) begin
            if (w_acc) begin
                r_col <= n_col[CW-1:0];
                r_row <= n_row[RW-1:0];
            end
            r_s1_v    <= w_acc;
            r_s2_meta <= n_s2_meta;
            r_s3_meta <= r_s2_meta;
            r_s4_meta <= r_s3_meta;
            r_s5_meta <= r_s4_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_addr <= w_cx[CW-1:0];
            r_s1_cur  <= w_cur;
            r_s1_meta <= n_meta;
        end
    end

    assign w_wr = {r_s1_cur, w_rd[1]};

    bfr_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_cx[CW-1:0]),
        .i_wr_en   (w_en & r_s1_v),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr),
        .o_rd_data (w_rd)
    );

    assign w_new_col = {r_s1_cur, w_rd[1], w_rd[0]};

    // window columns: the new column enters the right cell and moves left
    for (genvar k = 0; k < 3; k++) begin : g_cell
        bfr_cell #(
            .COL (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_shift (w_en & r_s1_v),
            .i_col   ((k == 2) ? w_new_col : w_cell_col[(k + 1) % 3]),
            .i_par   (r_s2_meta.par),
            .o_col   (w_cell_col[k]),
            .o_part  (w_part[k])
        );
    end

    always_comb begin
        for (int s = 0; s < 4; s++) begin
            n_sum[s] = '0;
            for (int k = 0; k < 3; k++) begin
                for (int r = 0; r < 3; r++) begin
                    n_sum[s] = n_sum[s] + SUM_W'(w_part[k][s][r]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= n_sum;
        end
    end

    // drop the fraction, clamp to 0..65535
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            if (r_sum[s][SUM_W-1] || (r_sum[s] == '0)) begin
                w_site[s] = '0;
            end else if (|r_sum[s][SUM_W-2:FRAC_W+16]) begin
                w_site[s] = 16'hFFFF;
            end else begin
                w_site[s] = r_sum[s][FRAC_W+15:FRAC_W];
            end
        end
    end

    bfr_outq u_outq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_meta         (r_s5_meta),
        .i_site         (w_site),
        .i_out_stall    (i_out_stall),
        .o_en           (w_en),
        .o_out_valid    (o_out_valid),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_is_border    (o_is_border),
        .o_last         (o_last)
    );

endmodule

>>> design/bfr_checker.sv
module bfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [10:0] o_out_col,
    input logic [15:0] o_top_left,
    input logic        o_is_border,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_col) &&
        $stable(o_top_left) && $stable(o_last))
        else $error("stalled item changed");

    a_border_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_border |-> o_last)
        else $error("border quad not last of its item");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !i_out_stall |=> o_out_valid && o_is_border)
        else $error("border quad missing after interior quad");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind dual_frame_bayer_recovery_filter_top bfr_checker u_bfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_col   (o_out_col),
    .o_top_left  (o_top_left),
    .o_is_border (o_is_border),
    .o_last      (o_last)
);
